// ----- src/srb_pkg.sv -----
// ----------------------------------------------------------------------------
// srb_pkg: sequence reorder buffer shared definitions
// Field widths, command codes, register map and the structs passed
// between the front, the command queue and the back.
// ----------------------------------------------------------------------------
package srb_pkg;

  localparam int SEQ_W       = 20;
  localparam int CNT_W       = 25;
  localparam int BUF_W       = 8;
  localparam int WINDOW_DEF  = 32;
  localparam int QUEUE_DEF   = 2;

  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 2;

  localparam logic [APB_ADDR_W-1:0] ADDR_STREAM_LEN = 2'd0;

  localparam logic [1:0] KIND_ERR   = 2'd0;
  localparam logic [1:0] KIND_PARK  = 2'd1;
  localparam logic [1:0] KIND_DELIV = 2'd2;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [CNT_W-1:0] byte_count;
    logic [BUF_W-1:0] buffer_id;
  } item_t;

  typedef struct packed {
    logic [1:0]       kind;
    item_t            item;
    logic [SEQ_W-1:0] off;
  } cmd_t;

  typedef struct packed {
    logic             vld;
    logic [BUF_W-1:0] buffer_id;
    logic [CNT_W-1:0] byte_count;
  } slot_word_t;

  typedef struct packed {
    logic             idle;
    logic [SEQ_W-1:0] next_expected;
  } back_stat_t;

endpackage

// ----- src/srb_if.sv -----
// ----------------------------------------------------------------------------
// srb_if: chunk and result channels
// Valid/ready channels carrying one arriving chunk word and one
// delivered result word.
// ----------------------------------------------------------------------------
interface srb_in_if;
  logic                      valid;
  logic                      ready;
  logic [srb_pkg::SEQ_W-1:0] seq;
  logic [srb_pkg::CNT_W-1:0] byte_count;
  logic [srb_pkg::BUF_W-1:0] buffer_id;

  modport source (output valid, output seq, output byte_count, output buffer_id,
                  input ready);
  modport sink (input valid, input seq, input byte_count, input buffer_id,
                output ready);
endinterface

interface srb_out_if;
  logic                      valid;
  logic                      ready;
  logic [srb_pkg::SEQ_W-1:0] out_seq;
  logic [srb_pkg::CNT_W-1:0] out_byte_count;
  logic [srb_pkg::BUF_W-1:0] out_buffer_id;
  logic                      last;
  logic                      error;
  logic                      done_res;

  modport source (output valid, output out_seq, output out_byte_count,
                  output out_buffer_id, output last, output error,
                  output done_res, input ready);
  modport sink (input valid, input out_seq, input out_byte_count,
                input out_buffer_id, input last, input error,
                input done_res, output ready);
endinterface

// ----- src/sequence_reorder_buffer_top.sv -----
// ----------------------------------------------------------------------------
// sequence_reorder_buffer_top: sequence reorder buffer
// Delivers out-of-order data chunks in sequence order through a window
// of parked slots, flagging stale, out-of-window and late chunks.
// ----------------------------------------------------------------------------
// After reset the block sweeps the WINDOW-entry slot memory before it takes
// the first chunk; configuration writes are taken meanwhile.
// One chunk is in flight at a time: the next chunk is accepted only after a
// parked or rejected chunk, or the burst of in-order words that a chunk
// releases, has been handled, one word per cycle while the result side keeps
// ready high. A chunk passes the intake register and the command queue, and a
// parked or delivered chunk also the registered read of the slot memory,
// which is read once per delivered word while a burst drains.
// The stream length lies at APB address 0 and must be written while the
// block is idle.
module sequence_reorder_buffer_top #(
  parameter int WINDOW      = srb_pkg::WINDOW_DEF,
  parameter int QUEUE_DEPTH = srb_pkg::QUEUE_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  srb_in_if.sink                         chunk,
  srb_out_if.source                      result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [srb_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [srb_pkg::APB_DATA_W-1:0] pwdata,
  output logic [srb_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  logic [srb_pkg::SEQ_W-1:0] stream_len;
  srb_pkg::back_stat_t       stat;
  srb_pkg::cmd_t             push_cmd;
  srb_pkg::cmd_t             pop_cmd;
  logic                      push;
  logic                      pop;
  logic                      q_empty;
  logic                      q_full;

  assign pready = 1'b1;
  assign prdata = (paddr == srb_pkg::ADDR_STREAM_LEN) ?
                  {{(srb_pkg::APB_DATA_W-srb_pkg::SEQ_W){1'b0}}, stream_len} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_len <= '0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == srb_pkg::ADDR_STREAM_LEN)) begin
      stream_len <= pwdata[srb_pkg::SEQ_W-1:0];
    end
  end

  srb_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .chunk      (chunk),
    .stream_len (stream_len),
    .stat       (stat),
    .q_empty    (q_empty),
    .q_full     (q_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  srb_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  srb_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .stream_len (stream_len),
    .cmd_valid  (!q_empty),
    .cmd        (pop_cmd),
    .pop        (pop),
    .stat       (stat),
    .result     (result)
  );

endmodule

// ----- src/srb_ram.sv -----
// ----------------------------------------------------------------------------
// srb_ram: generic simple dual port ram
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/srb_fifo.sv -----
// ----------------------------------------------------------------------------
// srb_fifo: command queue
// Short queue of classified commands between the front and the back.
// ----------------------------------------------------------------------------
module srb_fifo #(
  parameter int DEPTH = srb_pkg::QUEUE_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  srb_pkg::cmd_t push_cmd,
  input  logic          pop,
  output srb_pkg::cmd_t pop_cmd,
  output logic          empty,
  output logic          full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  srb_pkg::cmd_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ----- src/srb_front.sv -----
// ----------------------------------------------------------------------------
// srb_front: chunk intake and classification
// Takes one chunk word, checks it against the expected sequence number,
// the stream length and the window, and queues an error, park or deliver command.
// ----------------------------------------------------------------------------
module srb_front #(
  parameter int WINDOW = srb_pkg::WINDOW_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  srb_in_if.sink                    chunk,
  input  logic [srb_pkg::SEQ_W-1:0] stream_len,
  input  srb_pkg::back_stat_t       stat,
  input  logic                      q_empty,
  input  logic                      q_full,
  output logic                      push,
  output srb_pkg::cmd_t             cmd
);

  localparam logic [srb_pkg::SEQ_W-1:0] WIN = srb_pkg::SEQ_W'(WINDOW);

  logic                      held;
  srb_pkg::item_t            hold;
  logic [srb_pkg::SEQ_W-1:0] off;
  logic                      reject;

  assign chunk.ready = !held && stat.idle && q_empty;
  assign push        = held && !q_full;

  always_comb begin
    off    = hold.seq - stat.next_expected;
    reject = (stat.next_expected >= stream_len) || (hold.seq < stat.next_expected) ||
             (hold.seq >= stream_len) || (off >= WIN);
    cmd.item = hold;
    cmd.off  = off;
    if (reject) begin
      cmd.kind = srb_pkg::KIND_ERR;
    end else if (hold.seq == stat.next_expected) begin
      cmd.kind = srb_pkg::KIND_DELIV;
    end else begin
      cmd.kind = srb_pkg::KIND_PARK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (push) begin
      held <= 1'b0;
    end else if (chunk.valid && chunk.ready) begin
      held <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (chunk.valid && chunk.ready) begin
      hold.seq        <= chunk.seq;
      hold.byte_count <= chunk.byte_count;
      hold.buffer_id  <= chunk.buffer_id;
    end
  end

endmodule

// ----- src/srb_back.sv -----
// ----------------------------------------------------------------------------
// srb_back: slot store and in-order delivery
// Runs queued commands against the slot memory: parks chunks, reports
// rejects and drains consecutive parked chunks into the result register.
// ----------------------------------------------------------------------------
module srb_back #(
  parameter int WINDOW = srb_pkg::WINDOW_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [srb_pkg::SEQ_W-1:0] stream_len,
  input  logic                      cmd_valid,
  input  srb_pkg::cmd_t             cmd,
  output logic                      pop,
  output srb_pkg::back_stat_t       stat,
  srb_out_if.source                 result
);

  localparam int IDX_W = $clog2(WINDOW);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);
  localparam logic [IDX_W:0]   WIN_EXT  = (IDX_W+1)'(WINDOW);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ERR   = 3'd2;
  localparam logic [2:0] ST_PARK  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;

  function automatic logic [IDX_W-1:0] inc_slot(input logic [IDX_W-1:0] x);
    return (x == LAST_IDX) ? '0 : x + 1'b1;
  endfunction

  logic [2:0]                state, state_next;
  logic [srb_pkg::SEQ_W-1:0] ne, ne_next;
  logic [IDX_W-1:0]          ne_slot, ne_slot_next;
  logic [IDX_W-1:0]          clr_addr, clr_addr_next;
  logic [IDX_W-1:0]          pslot, pslot_next;
  logic [IDX_W-1:0]          burst, burst_next;
  srb_pkg::item_t            cur, cur_next;

  logic                      o_valid;
  srb_pkg::item_t            o_item;
  logic                      o_last;
  logic                      o_err;
  logic                      o_done;

  logic                      out_free;
  logic                      emit;
  logic                      e_last;
  logic                      e_err;
  logic                      e_done;
  logic                      more;
  logic [IDX_W:0]            psum;
  logic [IDX_W-1:0]          pslot_c;

  logic                      we;
  logic [IDX_W-1:0]          waddr;
  srb_pkg::slot_word_t       wdata;
  logic                      re;
  logic [IDX_W-1:0]          raddr;
  srb_pkg::slot_word_t       rdata;

  srb_ram #(
    .WIDTH ($bits(srb_pkg::slot_word_t)),
    .DEPTH (WINDOW)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_free           = !o_valid || result.ready;
  assign stat.idle          = (state == ST_IDLE);
  assign stat.next_expected = ne;

  // slot of a parked chunk: slot of next_expected plus its distance, wrapped
  assign psum    = {1'b0, ne_slot} + {1'b0, cmd.off[IDX_W-1:0]};
  assign pslot_c = (psum >= WIN_EXT) ? IDX_W'(psum - WIN_EXT) : psum[IDX_W-1:0];
  assign more    = (ne < stream_len) && rdata.vld;

  always_comb begin
    state_next    = state;
    ne_next       = ne;
    ne_slot_next  = ne_slot;
    clr_addr_next = clr_addr;
    pslot_next    = pslot;
    burst_next    = burst;
    cur_next      = cur;
    pop           = 1'b0;
    we            = 1'b0;
    waddr         = ne_slot;
    wdata         = '0;
    re            = 1'b0;
    raddr         = ne_slot;
    emit          = 1'b0;
    e_last        = 1'b1;
    e_err         = 1'b0;
    e_done        = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        if (clr_addr == LAST_IDX) begin
          state_next = ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          pop      = 1'b1;
          cur_next = cmd.item;
          unique case (cmd.kind)
            srb_pkg::KIND_PARK: begin
              re         = 1'b1;
              raddr      = pslot_c;
              pslot_next = pslot_c;
              state_next = ST_PARK;
            end
            srb_pkg::KIND_DELIV: begin
              ne_next      = cmd.item.seq + 1'b1;
              ne_slot_next = inc_slot(ne_slot);
              burst_next   = '0;
              re           = 1'b1;
              raddr        = inc_slot(ne_slot);
              state_next   = ST_DRAIN;
            end
            default: begin
              state_next = ST_ERR;
            end
          endcase
        end
      end
      ST_ERR: begin
        if (out_free) begin
          emit       = 1'b1;
          e_err      = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_PARK: begin
        if (rdata.vld) begin
          if (out_free) begin
            emit       = 1'b1;
            e_err      = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          we               = 1'b1;
          waddr            = pslot;
          wdata.vld        = 1'b1;
          wdata.buffer_id  = cur.buffer_id;
          wdata.byte_count = cur.byte_count;
          state_next       = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          emit   = 1'b1;
          e_last = !more;
          e_done = (ne == stream_len);
          // a burst ends after WINDOW words
          if (more && (burst != LAST_IDX)) begin
            we                  = 1'b1;
            waddr               = ne_slot;
            cur_next.seq        = ne;
            cur_next.byte_count = rdata.byte_count;
            cur_next.buffer_id  = rdata.buffer_id;
            ne_next             = ne + 1'b1;
            ne_slot_next        = inc_slot(ne_slot);
            burst_next          = burst + 1'b1;
            re                  = 1'b1;
            raddr               = inc_slot(ne_slot);
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      ne       <= '0;
      ne_slot  <= '0;
      clr_addr <= '0;
      o_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      ne       <= ne_next;
      ne_slot  <= ne_slot_next;
      clr_addr <= clr_addr_next;
      if (emit) begin
        o_valid <= 1'b1;
      end else if (result.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pslot <= pslot_next;
    burst <= burst_next;
    cur   <= cur_next;
    if (emit) begin
      o_item <= cur;
      o_last <= e_last;
      o_err  <= e_err;
      o_done <= e_done;
    end
  end

  assign result.valid          = o_valid;
  assign result.out_seq        = o_item.seq;
  assign result.out_byte_count = o_item.byte_count;
  assign result.out_buffer_id  = o_item.buffer_id;
  assign result.last           = o_last;
  assign result.error          = o_err;
  assign result.done_res       = o_done;

`ifndef ASSERT_OFF
  // completing the stream always closes the burst
  assert property (@(posedge clk) disable iff (rst) (o_valid && o_done) |-> o_last)
    else $error("done word without last");

  // a reject is a single word and never completes the stream
  assert property (@(posedge clk) disable iff (rst) (o_valid && o_err) |-> (o_last && !o_done))
    else $error("error word with bad flags");

  // slot of next_expected stays inside the window
  assert property (@(posedge clk) disable iff (rst) ne_slot <= LAST_IDX)
    else $error("slot index out of window");

  // no command is taken before the slot clearing pass ends
  assert property (@(posedge clk) disable iff (rst) (state == ST_CLEAR) |-> !pop)
    else $error("command popped during clear");
`endif

endmodule
